@@ hdl/tsb_pkg.sv @@
// shared types and constants for the timer slot bank
// no dependencies
`timescale 1ns / 1ps

package tsb_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int TIME_W     = 32;
    localparam int SLOT_IDX_W = 4;
    localparam int ALLOC_W    = 5;
    localparam int LIMIT_W    = 16;
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 48;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_DELETE  = 3'd2,
        OP_RESTART = 3'd3,
        OP_ENABLE  = 3'd4,
        OP_DISABLE = 3'd5,
        OP_TOGGLE  = 3'd6,
        OP_QUERY   = 3'd7
    } op_t;

    // command token walking down the row of slot cells
    typedef struct packed {
        logic                   valid;
        op_t                    op;
        logic [TIME_W-1:0]      now_ms;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic [TIME_W-1:0]      period_ms;
        logic [LIMIT_W-1:0]     run_limit;
        logic [ALLOC_W-1:0]     alloc;
        logic [MAX_SLOTS-1:0]   fired;
        logic [MAX_SLOTS-1:0]   retired;
        logic [SLOT_IDX_W-1:0]  granted;
        logic                   picked;
        logic                   ok;
        logic                   en;
    } token_t;

endpackage

@@ hdl/software_timer_slot_bank_top.sv @@
// Timer slot bank. A request on the s_ stream carries one command (tick,
// set, delete, restart, enable, disable, toggle, query) with the current
// millisecond time; each request gives exactly one result on the m_ stream.
// Slot state lives in a row of 16 slot cells. The controller launches a
// command token into the row; it moves one cell per cycle, each cell acting
// on its own slot and adding its fired/retired bits, grant or query answer.
// From request accept to m_tvalid the token passes one launch register,
// 16 cells and one output register. A new request is taken only once the
// token of the last one has left the row; only one token is in the row at
// a time.
// s_tready is low while a token is in the row, and also while a finished
// result is parked behind a stalled output. A stalled receiver holds
// m_tdata; one result may wait behind it, and a new request is taken while
// the first result still waits.
// Reset (aresetn low, synchronous) frees every slot, clears the allocation
// count and drops all tokens and results.
// depends on tsb_pkg and tsb_slot_cell
`timescale 1ns / 1ps

module software_timer_slot_bank_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[2:0], now_ms[34:3], slot_index[38:35], period_ms[70:39],
    // run_limit[86:71], zero fill
    input  logic [tsb_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fired_mask[15:0], retired_mask[31:16], granted_slot[35:32], ok[36],
    // slot_enabled[37], allocated_slots[42:38], zero fill
    output logic [tsb_pkg::M_DATA_W-1:0]  m_tdata
);
    import tsb_pkg::*;

    localparam int RES_W = 2 * MAX_SLOTS + SLOT_IDX_W + 2 + ALLOC_W;

    token_t                chain [MAX_SLOTS+1];
    token_t                launch_reg;
    token_t                launch_next;
    token_t                tail;

    logic                  busy_reg, busy_next;
    logic [ALLOC_W-1:0]    alloc_reg, alloc_next;
    logic                  m_valid_reg, m_valid_next;
    logic [RES_W-1:0]      m_res_reg, m_res_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [RES_W-1:0]      pend_res_reg, pend_res_next;
    logic [RES_W-1:0]      tail_res;
    logic                  s_accept;
    logic                  m_accept;

    assign s_tready = !busy_reg && !pend_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_valid_reg && m_tready;
    assign chain[0] = launch_reg;
    assign tail     = chain[MAX_SLOTS];
    assign tail_res = {tail.alloc, tail.en, tail.ok, tail.granted, tail.retired, tail.fired};

    always_comb begin
        launch_next            = '0;
        launch_next.valid      = s_accept;
        launch_next.op         = op_t'(s_tdata[2:0]);
        launch_next.now_ms     = s_tdata[34:3];
        launch_next.slot_index = s_tdata[38:35];
        launch_next.period_ms  = s_tdata[70:39];
        launch_next.run_limit  = s_tdata[86:71];
        launch_next.alloc      = alloc_reg;
        launch_next.ok         = (op_t'(s_tdata[2:0]) == OP_TICK);
    end

    always_comb begin
        busy_next       = busy_reg;
        alloc_next      = alloc_reg;
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (s_accept) begin
            busy_next = 1'b1;
        end
        if (m_accept) begin
            m_valid_next = pend_valid_reg;
            m_res_next   = pend_res_reg;
            if (pend_valid_reg) begin
                pend_valid_next = 1'b0;
            end
        end
        if (tail.valid) begin
            busy_next  = 1'b0;
            alloc_next = tail.alloc;
            if (!m_valid_reg || (m_accept && !pend_valid_reg)) begin
                m_valid_next = 1'b1;
                m_res_next   = tail_res;
            end else begin
                pend_valid_next = 1'b1;
                pend_res_next   = tail_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            alloc_reg      <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            launch_reg     <= '0;
        end else begin
            busy_reg       <= busy_next;
            alloc_reg      <= alloc_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            launch_reg     <= launch_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg    <= m_res_next;
        pend_res_reg <= pend_res_next;
    end

    for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
        tsb_slot_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_IDX_W'(i)),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - RES_W)'(0), m_res_reg};

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> busy_reg)
        else $error("accepted request did not mark the row busy");

    a_tail_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> busy_reg)
        else $error("token left the row with no request in flight");

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_valid_reg)
        else $error("parked result without a result on the output");

    a_alloc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_reg <= ALLOC_W'(MAX_SLOTS))
        else $error("allocation count beyond slot limit");

    a_launch_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[0].valid |-> $past(s_accept))
        else $error("token launched without an accepted request");
`endif

endmodule

@@ hdl/tsb_slot_cell.sv @@
// one timer slot: holds the slot state and acts on the passing command token
// depends on tsb_pkg
`timescale 1ns / 1ps

module tsb_slot_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tsb_pkg::SLOT_IDX_W-1:0] cell_idx,
    input  tsb_pkg::token_t                tok_in,
    output tsb_pkg::token_t                tok_out
);
    import tsb_pkg::*;

    logic                  active_reg, active_next;
    logic                  enable_reg, enable_next;
    logic [TIME_W-1:0]     period_reg, period_next;
    logic [TIME_W-1:0]     mark_reg, mark_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [LIMIT_W-1:0]    runs_reg, runs_next;
    token_t                tok_reg, tok_next;

    logic [TIME_W-1:0]     elapsed;
    logic [LIMIT_W-1:0]    runs_inc;
    logic                  below;
    logic                  addressed;

    assign elapsed   = tok_in.now_ms - mark_reg;
    assign runs_inc  = runs_reg + LIMIT_W'(1);
    assign below     = ALLOC_W'(cell_idx) < tok_in.alloc;
    assign addressed = below && (tok_in.slot_index == cell_idx);

    always_comb begin
        active_next = active_reg;
        enable_next = enable_reg;
        period_next = period_reg;
        mark_next   = mark_reg;
        limit_next  = limit_reg;
        runs_next   = runs_reg;
        tok_next    = tok_in;
        if (tok_in.valid) begin
            case (tok_in.op)
                OP_TICK: begin
                    if (below && active_reg && (elapsed >= period_reg)) begin
                        mark_next = mark_reg + period_reg;
                        if (enable_reg) begin
                            if (limit_reg == '0) begin
                                tok_next.fired[cell_idx] = 1'b1;
                            end else if (runs_reg < limit_reg) begin
                                tok_next.fired[cell_idx] = 1'b1;
                                runs_next = runs_inc;
                                if (runs_inc >= limit_reg) begin
                                    tok_next.retired[cell_idx] = 1'b1;
                                    active_next = 1'b0;
                                    enable_next = 1'b0;
                                    period_next = '0;
                                    runs_next   = '0;
                                end
                            end
                        end
                    end
                end
                OP_SET: begin
                    if (!tok_in.picked && ((below && !active_reg) ||
                                           (ALLOC_W'(cell_idx) == tok_in.alloc))) begin
                        active_next      = 1'b1;
                        enable_next      = 1'b1;
                        period_next      = tok_in.period_ms;
                        limit_next       = tok_in.run_limit;
                        runs_next        = '0;
                        mark_next        = tok_in.now_ms;
                        tok_next.granted = cell_idx;
                        tok_next.picked  = 1'b1;
                        tok_next.ok      = 1'b1;
                        if (!below) begin
                            tok_next.alloc = tok_in.alloc + ALLOC_W'(1);
                        end
                    end
                end
                OP_DELETE: begin
                    if (addressed) begin
                        tok_next.ok = 1'b1;
                        if (active_reg) begin
                            active_next = 1'b0;
                            enable_next = 1'b0;
                            period_next = '0;
                            runs_next   = '0;
                        end
                    end
                end
                OP_RESTART: begin
                    if (addressed) begin
                        tok_next.ok = 1'b1;
                        mark_next   = tok_in.now_ms;
                    end
                end
                OP_ENABLE: begin
                    if (addressed) begin
                        tok_next.ok = 1'b1;
                        enable_next = 1'b1;
                    end
                end
                OP_DISABLE: begin
                    if (addressed) begin
                        tok_next.ok = 1'b1;
                        enable_next = 1'b0;
                    end
                end
                OP_TOGGLE: begin
                    if (addressed) begin
                        tok_next.ok = 1'b1;
                        enable_next = !enable_reg;
                    end
                end
                OP_QUERY: begin
                    if (addressed) begin
                        tok_next.ok = 1'b1;
                        tok_next.en = enable_reg;
                    end
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            enable_reg <= 1'b0;
            tok_reg    <= '0;
        end else begin
            active_reg <= active_next;
            enable_reg <= enable_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        mark_reg   <= mark_next;
        limit_reg  <= limit_next;
        runs_reg   <= runs_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ dv/software_timer_slot_bank_top_tb.sv @@
// testbench for software_timer_slot_bank_top: drives command requests, predicts every
// result from its own copy of the slot bank and checks results as they leave
// depends on tsb_pkg and the software_timer_slot_bank_top rtl
`timescale 1ns / 1ps

module software_timer_slot_bank_top_tb;
    import tsb_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [ALLOC_W-1:0]    allocated_slots;
        logic                  slot_enabled;
        logic                  ok;
        logic [SLOT_IDX_W-1:0] granted_slot;
        logic [MAX_SLOTS-1:0]  retired_mask;
        logic [MAX_SLOTS-1:0]  fired_mask;
    } bank_result_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // slot bank mirror
    bit                 bank_active [MAX_SLOTS];
    bit                 bank_enable [MAX_SLOTS];
    logic [TIME_W-1:0]  bank_period [MAX_SLOTS];
    logic [TIME_W-1:0]  bank_mark   [MAX_SLOTS];
    logic [LIMIT_W-1:0] bank_limit  [MAX_SLOTS];
    logic [LIMIT_W-1:0] bank_runs   [MAX_SLOTS];
    int                 bank_allocated = 0;

    bank_result_t       pending_results [$];
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    int                 stall_left = 0;
    bit                 idle_off = 1'b0;
    logic [TIME_W-1:0]  cur_ms = 32'd100;

    software_timer_slot_bank_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void release_slot(int i);
        bank_active[i] = 1'b0;
        bank_enable[i] = 1'b0;
        bank_period[i] = '0;
        bank_runs[i]   = '0;
    endfunction

    function automatic bank_result_t apply_command(op_t op, logic [TIME_W-1:0] now,
                                                   logic [SLOT_IDX_W-1:0] idx,
                                                   logic [TIME_W-1:0] period,
                                                   logic [LIMIT_W-1:0] limit);
        bank_result_t r;
        logic [TIME_W-1:0] elapsed;
        int pick;
        r = '0;
        case (op)
            OP_TICK: begin
                r.ok = 1'b1;
                for (int i = 0; i < bank_allocated; i++) begin
                    elapsed = now - bank_mark[i];
                    if (bank_active[i] && elapsed >= bank_period[i]) begin
                        bank_mark[i] = bank_mark[i] + bank_period[i];
                        if (bank_enable[i]) begin
                            if (bank_limit[i] == '0) begin
                                r.fired_mask[i] = 1'b1;
                            end else if (bank_runs[i] < bank_limit[i]) begin
                                r.fired_mask[i] = 1'b1;
                                bank_runs[i] = bank_runs[i] + LIMIT_W'(1);
                                if (bank_runs[i] >= bank_limit[i]) begin
                                    r.retired_mask[i] = 1'b1;
                                    release_slot(i);
                                end
                            end
                        end
                    end
                end
            end
            OP_SET: begin
                pick = -1;
                for (int i = 0; i < bank_allocated; i++) begin
                    if (pick < 0 && !bank_active[i]) pick = i;
                end
                if (pick < 0 && bank_allocated < MAX_SLOTS) begin
                    pick = bank_allocated;
                    bank_allocated++;
                end
                if (pick >= 0) begin
                    bank_active[pick] = 1'b1;
                    bank_enable[pick] = 1'b1;
                    bank_period[pick] = period;
                    bank_limit[pick]  = limit;
                    bank_runs[pick]   = '0;
                    bank_mark[pick]   = now;
                    r.granted_slot    = SLOT_IDX_W'(pick);
                    r.ok              = 1'b1;
                end
            end
            default: begin
                if (int'(idx) < bank_allocated) begin
                    r.ok = 1'b1;
                    case (op)
                        OP_DELETE:  if (bank_active[idx]) release_slot(int'(idx));
                        OP_RESTART: bank_mark[idx] = now;
                        OP_ENABLE:  bank_enable[idx] = 1'b1;
                        OP_DISABLE: bank_enable[idx] = 1'b0;
                        OP_TOGGLE:  bank_enable[idx] = !bank_enable[idx];
                        default:    r.slot_enabled = bank_enable[idx];
                    endcase
                end
            end
        endcase
        r.allocated_slots = ALLOC_W'(bank_allocated);
        return r;
    endfunction

    task automatic send_request(input op_t op, input logic [TIME_W-1:0] now,
                                input logic [SLOT_IDX_W-1:0] idx,
                                input logic [TIME_W-1:0] period,
                                input logic [LIMIT_W-1:0] limit);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, limit, period, idx, now, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_command(op, now, idx, period, limit));
        if (!idle_off && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 24);
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [TIME_W-1:0] random_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 90) return $urandom_range(0, 100);
        return $urandom;
    endfunction

    function automatic logic [LIMIT_W-1:0] random_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return '0;
        if (r < 85) return LIMIT_W'($urandom_range(1, 5));
        return LIMIT_W'($urandom);
    endfunction

    function automatic void advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) cur_ms = $urandom;
        else if (r < 5) cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else cur_ms = cur_ms + $urandom_range(0, 4);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        bank_result_t got;
        bank_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = bank_result_t'(m_tdata[42:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("fired_mask", 32'(want.fired_mask), 32'(got.fired_mask));
                compare_field("retired_mask", 32'(want.retired_mask),
                              32'(got.retired_mask));
                compare_field("granted_slot", 32'(want.granted_slot),
                              32'(got.granted_slot));
                compare_field("ok", 32'(want.ok), 32'(got.ok));
                compare_field("slot_enabled", 32'(want.slot_enabled),
                              32'(got.slot_enabled));
                compare_field("allocated_slots", 32'(want.allocated_slots),
                              32'(got.allocated_slots));
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_off) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 99) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(20, 60);
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 30);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed_commands();
        send_request(OP_QUERY, 32'd100, 4'd0, '0, '0);
        send_request(OP_DELETE, 32'd100, 4'd15, '0, '0);
        send_request(OP_TICK, 32'd100, 4'd0, '0, '0);
        send_request(OP_SET, 32'd100, 4'd0, 32'd0, 16'd0);
        send_request(OP_SET, 32'd100, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_SET, 32'd100, 4'd0, 32'd10, 16'd1);
        send_request(OP_SET, 32'd100, 4'd0, 32'd5, 16'd3);
        send_request(OP_TICK, 32'd100, 4'd0, '0, '0);
        send_request(OP_DISABLE, 32'd101, 4'd0, '0, '0);
        // disabled but due: mark moves, no fire
        send_request(OP_TICK, 32'd105, 4'd0, '0, '0);
        send_request(OP_TOGGLE, 32'd106, 4'd0, '0, '0);
        send_request(OP_QUERY, 32'd106, 4'd0, '0, '0);
        send_request(OP_TICK, 32'd110, 4'd0, '0, '0);
        // slot 2 retired above, act on it while freed
        send_request(OP_DELETE, 32'd111, 4'd2, '0, '0);
        send_request(OP_RESTART, 32'd111, 4'd2, '0, '0);
        send_request(OP_ENABLE, 32'd111, 4'd2, '0, '0);
        send_request(OP_TICK, 32'd120, 4'd0, '0, '0);
        send_request(OP_SET, 32'hFFFF_FFF8, 4'd0, 32'd8, 16'd0);
        send_request(OP_DELETE, 32'hFFFF_FFF9, 4'd1, '0, '0);
        send_request(OP_QUERY, 32'hFFFF_FFF9, 4'd1, '0, '0);
        // time wraps past zero
        send_request(OP_TICK, 32'h0000_0002, 4'd0, '0, '0);
        send_request(OP_TICK, 32'hFFFF_FFFF, 4'd0, '0, '0);
        send_request(OP_QUERY, 32'hFFFF_FFFF, 4'd15, '0, '0);
    endtask

    task automatic test_full_bank();
        cur_ms = 32'd5000;
        repeat (18) begin
            cur_ms = cur_ms + 1;
            send_request(OP_SET, cur_ms, 4'd0, random_period(), 16'd0);
        end
        send_request(OP_QUERY, cur_ms, 4'd15, '0, '0);
        send_request(OP_DELETE, cur_ms, 4'd7, '0, '0);
        send_request(OP_SET, cur_ms, 4'd0, 32'd3, 16'd2);
        send_request(OP_SET, cur_ms, 4'd0, 32'd3, 16'd2);
        send_request(OP_TICK, cur_ms + 32'd3, 4'd0, '0, '0);
        send_request(OP_TICK, cur_ms + 32'd6, 4'd0, '0, '0);
        send_request(OP_SET, cur_ms + 32'd6, 4'd0, 32'd1, 16'd1);
    endtask

    task automatic test_random_mix(input int count);
        op_t op;
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 40) op = OP_TICK;
            else if (r < 60) op = OP_SET;
            else op = op_t'($urandom_range(2, 7));
            advance_clock();
            send_request(op, cur_ms, SLOT_IDX_W'($urandom_range(0, 15)),
                         random_period(), random_limit());
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_off = 1'b1;
        test_random_mix(count);
        idle_off = 1'b0;
    endtask

    task automatic test_drain_then_resume();
        int hold;
        test_random_mix(20);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        hold = $urandom_range(1, 20);
        repeat (hold) @(posedge aclk);
        test_random_mix(20);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_full_bank();
        test_random_mix(300);
        test_back_to_back(150);
        test_drain_then_resume();
        test_random_mix(230);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ software_timer_slot_bank_top.f @@
hdl/tsb_pkg.sv
hdl/tsb_slot_cell.sv
hdl/software_timer_slot_bank_top.sv
dv/software_timer_slot_bank_top_tb.sv
